[sv/pulse_jet_valve_sequencer_assert.svh]
// assertion macros shared by the sequencer rtl
`ifndef PULSE_JET_VALVE_SEQUENCER_ASSERT_SVH
`define PULSE_JET_VALVE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is held
`define PJVS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define PJVS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PJVS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PJVS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[sv/pjvs_pkg.sv]
package pjvs_pkg;

    // payload widths
    localparam int PRESSURE_W = 10;
    localparam int TICKS_W    = 16;
    localparam int DRIVE_W    = 8;
    localparam int SEL_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAIT_TICKS   = 3'd0,
        REG_PULSE_TICKS  = 3'd1,
        REG_GAP_TICKS    = 3'd2,
        REG_SETTLE_TICKS = 3'd3,
        REG_FAULT_THRESH = 3'd4,
        REG_MANUAL_TICKS = 3'd5
    } t_reg_idx;

    // register reset values
    localparam logic [TICKS_W-1:0]    WAIT_TICKS_RST   = 16'd3000;
    localparam logic [TICKS_W-1:0]    PULSE_TICKS_RST  = 16'd200;
    localparam logic [TICKS_W-1:0]    GAP_TICKS_RST    = 16'd500;
    localparam logic [TICKS_W-1:0]    SETTLE_TICKS_RST = 16'd100;
    localparam logic [PRESSURE_W-1:0] FAULT_THRESH_RST = 10'd819;
    localparam logic [TICKS_W-1:0]    MANUAL_TICKS_RST = 16'd200;

    // automatic sequence phases
    typedef enum logic [3:0] {
        PH_WAIT   = 4'b0001,
        PH_PULSE  = 4'b0010,
        PH_GAP    = 4'b0100,
        PH_SETTLE = 4'b1000
    } t_phase;

endpackage

[sv/pjvs_in_if.sv]
interface pjvs_in_if;
    logic                                valid;
    logic                                ready;
    logic [pjvs_pkg::PRESSURE_W-1:0]     pressure;
    logic                                auto_select;
    logic                                inc_press;
    logic                                dec_press;
    logic                                enter_press;
    logic                                reset_press;

    modport source (
        output valid, pressure, auto_select, inc_press, dec_press, enter_press, reset_press,
        input  ready
    );
    modport sink (
        input  valid, pressure, auto_select, inc_press, dec_press, enter_press, reset_press,
        output ready
    );
endinterface

[sv/pjvs_out_if.sv]
interface pjvs_out_if;
    logic                              valid;
    logic                              ready;
    logic [pjvs_pkg::DRIVE_W-1:0]      valve_drive;
    logic                              cycle_active;
    logic                              pressure_fault;
    logic [pjvs_pkg::TICKS_W-1:0]      cycle_total;
    logic [pjvs_pkg::SEL_W-1:0]        chosen_valve;
    logic                              store_count;

    modport source (
        output valid, valve_drive, cycle_active, pressure_fault, cycle_total,
               chosen_valve, store_count,
        input  ready
    );
    modport sink (
        input  valid, valve_drive, cycle_active, pressure_fault, cycle_total,
               chosen_valve, store_count,
        output ready
    );
endinterface

[sv/pulse_jet_valve_sequencer.sv]
// pulse-jet filter cleaning sequencer: every input word is one 10 ms tick carrying a
// pressure sample, the auto/manual switch level and debounced button events, and it
// gives exactly one output word with the valve drive bits, the lamps, the cycle count,
// the manually selected valve and a store request for the count. one word is taken on
// every clock while the output side keeps up; the result appears in the cycle after the
// word is taken, held in a single output register that also decouples the two sides,
// so a stalled consumer only stops intake once that register is full and not read.
// the tick update is a handful of combinational 16-bit compares and counters.
// configuration registers (index: wait, pulse, gap, settle, fault threshold, manual length)
// use the plain write port; the user must write them only while no word is in flight, unenforced.
`include "pulse_jet_valve_sequencer_assert.svh"

module pulse_jet_valve_sequencer #(
    parameter int VALVE_COUNT = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pjvs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pjvs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pjvs_in_if.sink                           i_in,
    pjvs_out_if.source                        o_out
);
    import pjvs_pkg::*;

    // valves reachable by selection and the all-valve firing
    localparam int SPAN = (VALVE_COUNT > 8) ? 8 : VALVE_COUNT;
    localparam int VI_W = (VALVE_COUNT > 1) ? $clog2(VALVE_COUNT) : 1;
    localparam logic [DRIVE_W-1:0] ALL_MASK  = DRIVE_W'((1 << SPAN) - 1);
    localparam logic [SEL_W-1:0]   SEL_LAST  = SEL_W'(SPAN - 1);
    localparam logic [VI_W-1:0]    VI_LAST   = VI_W'(VALVE_COUNT - 1);

    // configuration registers
    logic [TICKS_W-1:0]    r_wait_ticks;
    logic [TICKS_W-1:0]    r_pulse_ticks;
    logic [TICKS_W-1:0]    r_gap_ticks;
    logic [TICKS_W-1:0]    r_settle_ticks;
    logic [PRESSURE_W-1:0] r_fault_thresh;
    logic [TICKS_W-1:0]    r_manual_ticks;

    // sequencer state
    t_phase                r_phase,    n_phase;
    logic [TICKS_W-1:0]    r_phase_cnt, n_phase_cnt;
    logic [VI_W-1:0]       r_valve_idx, n_valve_idx;
    logic [TICKS_W-1:0]    r_cycles,   n_cycles;
    logic                  r_auto,     n_auto;
    logic [SEL_W-1:0]      r_sel,      n_sel;
    logic [TICKS_W-1:0]    r_man_cnt,  n_man_cnt;
    logic [DRIVE_W-1:0]    r_mask,     n_mask;
    logic                  r_active,   n_active;

    // output register
    logic                  r_out_valid;
    logic [DRIVE_W-1:0]    r_out_drive,  n_out_drive;
    logic                  r_out_fault,  n_out_fault;
    logic                  r_out_store,  n_out_store;

    logic                  w_accept;
    logic                  w_fault;
    logic                  w_busy;
    logic                  w_fired;
    logic [DRIVE_W-1:0]    w_auto_bits;

    // the output register frees up in the same clock it is read
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // ---------------------------------------------------------------- config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks   <= WAIT_TICKS_RST;
            r_pulse_ticks  <= PULSE_TICKS_RST;
            r_gap_ticks    <= GAP_TICKS_RST;
            r_settle_ticks <= SETTLE_TICKS_RST;
            r_fault_thresh <= FAULT_THRESH_RST;
            r_manual_ticks <= MANUAL_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_WAIT_TICKS:   r_wait_ticks   <= i_cfg_data;
                REG_PULSE_TICKS:  r_pulse_ticks  <= i_cfg_data;
                REG_GAP_TICKS:    r_gap_ticks    <= i_cfg_data;
                REG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data;
                REG_FAULT_THRESH: r_fault_thresh <= i_cfg_data[PRESSURE_W-1:0];
                REG_MANUAL_TICKS: r_manual_ticks <= i_cfg_data;
                default: begin
                    // unused indexes are ignored
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- tick update
    always_comb begin
        n_phase     = r_phase;
        n_phase_cnt = r_phase_cnt;
        n_valve_idx = r_valve_idx;
        n_cycles    = r_cycles;
        n_auto      = r_auto;
        n_sel       = r_sel;
        n_man_cnt   = r_man_cnt;
        n_mask      = r_mask;
        n_active    = r_active;
        n_out_store = 1'b0;
        w_auto_bits = '0;
        w_fired     = 1'b0;

        w_fault = i_in.pressure > r_fault_thresh;
        // a firing from an earlier tick locks out the manual buttons
        w_busy  = r_mask != '0;

        // reset button, judged by the mode held before this tick
        if (i_in.reset_press) begin
            if (r_auto) begin
                n_cycles    = '0;
                n_out_store = 1'b1;
            end else if (!w_busy) begin
                n_mask    = ALL_MASK;
                n_man_cnt = '0;
                w_fired   = 1'b1;
            end
        end

        // mode switch: leaving auto keeps the sequence where it stands
        if (!i_in.auto_select && r_auto) begin
            n_auto   = 1'b0;
            n_active = 1'b0;
        end else if (i_in.auto_select && !r_auto) begin
            n_auto = 1'b1;
        end

        // manual stepping with wrap, then enter fires the chosen valve
        if (!n_auto && !w_busy) begin
            if (i_in.inc_press) begin
                n_sel = (n_sel == SEL_LAST) ? '0 : n_sel + 1'b1;
            end
            if (i_in.dec_press) begin
                n_sel = (n_sel == '0) ? SEL_LAST : n_sel - 1'b1;
            end
            if (i_in.enter_press && !w_fired) begin
                n_mask    = DRIVE_W'(1) << n_sel;
                n_man_cnt = '0;
            end
        end

        // firing countdown, runs in either mode and through a fault
        if (n_mask != '0) begin
            if (n_man_cnt >= r_manual_ticks) begin
                n_mask    = '0;
                n_man_cnt = '0;
            end else begin
                n_man_cnt = n_man_cnt + 1'b1;
            end
        end

        // automatic sequence, held on a fault
        if (n_auto) begin
            if (w_fault) begin
                n_active = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_WAIT: begin
                        n_active = 1'b0;
                        if (r_phase_cnt >= r_wait_ticks) begin
                            n_phase     = PH_PULSE;
                            n_phase_cnt = '0;
                            n_valve_idx = '0;
                            n_active    = 1'b1;
                            n_cycles    = n_cycles + 1'b1;
                            n_out_store = 1'b1;
                        end else begin
                            n_phase_cnt = r_phase_cnt + 1'b1;
                        end
                    end
                    PH_PULSE: begin
                        if (r_phase_cnt >= r_pulse_ticks) begin
                            n_phase     = PH_GAP;
                            n_phase_cnt = '0;
                        end else begin
                            n_phase_cnt = r_phase_cnt + 1'b1;
                            // valves from the ninth on have no drive bit
                            if (32'(r_valve_idx) < DRIVE_W) begin
                                w_auto_bits = DRIVE_W'(1) << r_valve_idx;
                            end
                        end
                    end
                    PH_GAP: begin
                        if (r_phase_cnt >= r_gap_ticks) begin
                            n_phase_cnt = '0;
                            if (r_valve_idx == VI_LAST) begin
                                n_phase     = PH_SETTLE;
                                n_active    = 1'b0;
                                n_valve_idx = '0;
                            end else begin
                                n_phase     = PH_PULSE;
                                n_valve_idx = r_valve_idx + 1'b1;
                            end
                        end else begin
                            n_phase_cnt = r_phase_cnt + 1'b1;
                        end
                    end
                    PH_SETTLE: begin
                        if (r_phase_cnt >= r_settle_ticks) begin
                            n_phase     = PH_WAIT;
                            n_phase_cnt = '0;
                        end else begin
                            n_phase_cnt = r_phase_cnt + 1'b1;
                        end
                    end
                    default: begin
                        n_phase     = PH_WAIT;
                        n_phase_cnt = '0;
                    end
                endcase
            end
        end

        n_out_fault = w_fault;
        n_out_drive = w_fault ? '0 : (w_auto_bits | n_mask);
    end

    // state advances only on a taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_phase_cnt <= '0;
            r_valve_idx <= '0;
            r_cycles    <= '0;
            r_auto      <= 1'b0;
            r_sel       <= '0;
            r_man_cnt   <= '0;
            r_mask      <= '0;
            r_active    <= 1'b0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_phase_cnt <= n_phase_cnt;
            r_valve_idx <= n_valve_idx;
            r_cycles    <= n_cycles;
            r_auto      <= n_auto;
            r_sel       <= n_sel;
            r_man_cnt   <= n_man_cnt;
            r_mask      <= n_mask;
            r_active    <= n_active;
        end
    end

    // ---------------------------------------------------------------- output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_drive <= n_out_drive;
            r_out_fault <= n_out_fault;
            r_out_store <= n_out_store;
        end
    end

    // cycle count, lamp and selection come straight from the state just written
    assign o_out.valid          = r_out_valid;
    assign o_out.valve_drive    = r_out_drive;
    assign o_out.cycle_active   = r_active;
    assign o_out.pressure_fault = r_out_fault;
    assign o_out.cycle_total    = r_cycles;
    assign o_out.chosen_valve   = r_sel;
    assign o_out.store_count    = r_out_store;

    // ---------------------------------------------------------------- checks
    `PJVS_ASSERT(a_fault_closes_all, i_clk, i_rst_n, r_out_valid && r_out_fault |-> r_out_drive == '0, "valves open during pressure fault")
    `PJVS_ASSERT(a_active_needs_auto, i_clk, i_rst_n, r_active |-> r_auto, "cycle active lamp outside automatic mode")
    `PJVS_ASSERT(a_wait_not_active, i_clk, i_rst_n, r_phase == PH_WAIT |-> !r_active, "cycle active lamp in wait phase")
    `PJVS_ASSERT(a_mask_shape, i_clk, i_rst_n, r_mask != '0 |-> $onehot(r_mask) || r_mask == ALL_MASK, "manual firing mask malformed")
    `PJVS_ASSERT(a_accept_fills, i_clk, i_rst_n, w_accept |=> r_out_valid, "taken word produced no output word")
    `PJVS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_out_valid, "output word valid after reset")

endmodule
